// ===== sv/stp_pkg.sv =====
// section timing profiler package: status codes, widths, default sizes
// no dependencies
`default_nettype none
package stp_pkg;
	localparam int THREAD_SLOTS_DEF = 4;
	localparam int ENTRIES_DEF = 16;
	localparam int TAG_BITS_DEF = 32;
	localparam int TIME_W = 63;
	localparam logic [62:0] DUR_MAX = 63'h7fffffffffffffff;
	localparam logic [2:0] ST_RESTART = 3'd0;
	localparam logic [2:0] ST_CREATED = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_UPDATED = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;
endpackage
`default_nettype wire

// ===== sv/section_timing_profiler_core.sv =====
// section timing profiler top level: per-thread section table with search sequencer
// depends on stp_pkg
//
// Each event is one input transaction; the result is one output transaction. The
// thread table is scanned one entry per cycle by a single tag comparator. A begin,
// or an end whose tag is not found, passes through the scan, read, calc and write
// states before its result is registered. An end that finds its entry also passes
// through the update state for the total and min/max update. Then the core waits
// until the result is taken and is ready again in the cycle after that. The table
// sits in one memory of THREAD_SLOTS*ENTRIES_PER_THREAD rows with registered read
// data; row validity is kept in flip-flops cleared at reset, so no clearing pass
// is needed. An end applies one 64-bit add for the total and the min/max updates
// in the same cycle.
`default_nettype none
module section_timing_profiler_core #(
	parameter int THREAD_SLOTS = stp_pkg::THREAD_SLOTS_DEF,
	parameter int ENTRIES_PER_THREAD = stp_pkg::ENTRIES_DEF,
	parameter int TAG_BITS = stp_pkg::TAG_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// tdata: thread_slot[1:0], tag_key[33:2], timestamp[96:34], zero fill to 104
	input wire logic [103:0] s_tdata,
	// tuser: func
	input wire logic s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// tdata: status[2:0], entry_index[6:3], elapsed[69:7], total_time[133:70],
	// call_count[165:134], min_first[228:166], min_second[291:229],
	// max_first[354:292], max_second[417:355], zero fill to 424
	output logic [423:0] m_tdata
);
	import stp_pkg::*;

	localparam int EW = (ENTRIES_PER_THREAD > 1) ? $clog2(ENTRIES_PER_THREAD) : 1;
	localparam int SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
	localparam int ROWS = THREAD_SLOTS * ENTRIES_PER_THREAD;
	localparam int AW = SW + EW;
	localparam int CW = EW + 1;
	localparam int RW = TAG_BITS + 63 + 64 + 32 + 4 * 63;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_SCAN = 7'b0000010,
		S_READ = 7'b0000100,
		S_CALC = 7'b0001000,
		S_UPD = 7'b0010000,
		S_WRITE = 7'b0100000,
		S_OUT = 7'b1000000
	} state_t;

	typedef struct packed {
		logic [TAG_BITS-1:0] tag;
		logic [62:0] start;
		logic [63:0] total;
		logic [31:0] calls;
		logic [62:0] mn0;
		logic [62:0] mn1;
		logic [62:0] mx0;
		logic [62:0] mx1;
	} row_t;

	state_t state_q;
	logic [ROWS-1:0] valid_q;
	row_t mem_q [ROWS];
	row_t rd_q;
	row_t wr_row;
	row_t upd_row;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic wr_en;

	logic func_q;
	logic [1:0] slot_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [62:0] now_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] scan_q;
	logic hit_q;
	logic [EW-1:0] hit_idx_q;
	logic free_q;
	logic [EW-1:0] free_idx_q;
	logic rd_pend_q;
	logic [62:0] dur_q;
	row_t new_q;
	logic [2:0] st_q;
	logic [EW-1:0] idx_q;

	logic [31:0] in_tag;
	logic [AW-1:0] base;
	logic [EW-1:0] scan_idx;
	logic slot_ok;
	logic end_hit;
	logic [64:0] sum;

	assign in_tag = s_tdata[33:2];
	assign slot_ok = ({30'd0, slot_q} < 32'(THREAD_SLOTS));
	assign end_hit = slot_ok && func_q && hit_q;
	assign base = AW'(slot_q) * AW'(ENTRIES_PER_THREAD);
	assign scan_idx = cnt_q[EW-1:0];
	assign s_tready = (state_q == S_IDLE);

	// memory read address: scan pointer, then the chosen entry
	always_comb begin
		rd_addr = base + AW'(scan_idx);
		if (state_q != S_SCAN) rd_addr = base + AW'(hit_idx_q);
	end

	// table memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_row;
		rd_q <= mem_q[rd_addr];
	end

	assign wr_en = (state_q == S_WRITE) && (st_q != ST_FULL) && (st_q != ST_NOTFOUND);
	assign wr_addr = base + AW'(idx_q);
	assign wr_row = new_q;
	assign sum = {1'b0, rd_q.total} + {2'b0, dur_q};

	// end update: saturating total and count, two smallest and two largest
	always_comb begin
		upd_row = rd_q;
		upd_row.total = sum[64] ? '1 : sum[63:0];
		if (rd_q.calls != '1) upd_row.calls = rd_q.calls + 32'd1;
		if (rd_q.mn0 > dur_q) begin
			upd_row.mn1 = rd_q.mn0;
			upd_row.mn0 = dur_q;
		end else if (rd_q.mn1 > dur_q) upd_row.mn1 = dur_q;
		if (rd_q.mx0 < dur_q) begin
			upd_row.mx1 = rd_q.mx0;
			upd_row.mx0 = dur_q;
		end else if (rd_q.mx1 < dur_q) upd_row.mx1 = dur_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			m_tvalid <= 1'b0;
			cnt_q <= '0;
			scan_q <= '0;
			rd_pend_q <= 1'b0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						func_q <= s_tuser;
						slot_q <= s_tdata[1:0];
						tag_q <= TAG_BITS'({32'd0, in_tag} & ((64'd1 << TAG_BITS) - 64'd1));
						now_q <= s_tdata[96:34];
						cnt_q <= '0;
						hit_q <= 1'b0;
						free_q <= 1'b0;
						hit_idx_q <= '0;
						free_idx_q <= '0;
						rd_pend_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// compare the entry read last cycle, one per cycle
					if (rd_pend_q) begin
						if (valid_q[base + AW'(scan_q[EW-1:0])]) begin
							if (!hit_q && rd_q.tag == tag_q) begin
								hit_q <= 1'b1;
								hit_idx_q <= scan_q[EW-1:0];
							end
						end else if (!free_q) begin
							free_q <= 1'b1;
							free_idx_q <= scan_q[EW-1:0];
						end
					end
					scan_q <= cnt_q;
					if (cnt_q == CW'(ENTRIES_PER_THREAD)) begin
						rd_pend_q <= 1'b0;
						state_q <= S_READ;
					end else begin
						rd_pend_q <= 1'b1;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_READ: state_q <= S_CALC;
				S_CALC: begin
					if (slot_ok && !func_q && hit_q) begin
						st_q <= ST_RESTART;
						idx_q <= hit_idx_q;
						new_q <= '{tag: rd_q.tag, start: now_q, total: rd_q.total,
							calls: rd_q.calls, mn0: rd_q.mn0, mn1: rd_q.mn1,
							mx0: rd_q.mx0, mx1: rd_q.mx1};
					end else if (slot_ok && !func_q && free_q) begin
						st_q <= ST_CREATED;
						idx_q <= free_idx_q;
						new_q <= '{tag: tag_q, start: now_q, total: '0, calls: '0,
							mn0: DUR_MAX, mn1: DUR_MAX, mx0: '0, mx1: '0};
					end else begin
						new_q <= rd_q;
						if (!slot_ok) st_q <= func_q ? ST_NOTFOUND : ST_FULL;
						else if (!func_q) st_q <= ST_FULL;
						else if (hit_q) begin
							st_q <= ST_UPDATED;
							idx_q <= hit_idx_q;
						end else st_q <= ST_NOTFOUND;
					end
					dur_q <= (end_hit && now_q >= rd_q.start) ? now_q - rd_q.start : '0;
					state_q <= end_hit ? S_UPD : S_WRITE;
				end
				S_UPD: begin
					new_q <= upd_row;
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (st_q == ST_CREATED) valid_q[base + AW'(idx_q)] <= 1'b1;
					m_tvalid <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: if (m_tready) begin
					m_tvalid <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result packing
	logic nz;
	assign nz = (st_q != ST_FULL) && (st_q != ST_NOTFOUND);
	always_comb begin
		m_tdata = '0;
		m_tdata[2:0] = st_q;
		if (nz) begin
			m_tdata[6:3] = 4'(idx_q);
			m_tdata[69:7] = dur_q;
			m_tdata[133:70] = new_q.total;
			m_tdata[165:134] = new_q.calls;
			m_tdata[228:166] = new_q.mn0;
			m_tdata[291:229] = new_q.mn1;
			m_tdata[354:292] = new_q.mx0;
			m_tdata[417:355] = new_q.mx1;
		end
	end

	// checks
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("ready while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= ST_NOTFOUND) else $error("bad status");
endmodule
`default_nettype wire
